@@ rtl/core/swfr_pkg.sv @@
`timescale 1ns / 1ps

package swfr_pkg;

  localparam int SEQ_BITS = 3;
  localparam int OP_BITS = 2;
  localparam int EV_BITS = 3;
  localparam int SLOT_BITS = 3;
  localparam int CNT_BITS = 4;
  localparam int MAX_PAYLOAD_BITS = 64;

  localparam logic [OP_BITS-1:0] OP_SEND = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ACK = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [EV_BITS-1:0] EV_REFUSED = 3'd0;
  localparam logic [EV_BITS-1:0] EV_TRANSMIT = 3'd1;
  localparam logic [EV_BITS-1:0] EV_STOP = 3'd2;
  localparam logic [EV_BITS-1:0] EV_RETRANSMIT = 3'd3;
  localparam logic [EV_BITS-1:0] EV_NONE = 3'd4;

  localparam logic [1:0] DUP_LIMIT = 2'd3;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // One classified request: a run of count results starting at seq.
  typedef struct packed {
    logic [EV_BITS-1:0]          event_res;
    logic [SEQ_BITS-1:0]         seq;
    logic [CNT_BITS-1:0]         count;
    logic [SLOT_BITS-1:0]        slot;
    logic                        wr_slot;
    logic                        rd_slot;
    logic                        window_full;
    logic [MAX_PAYLOAD_BITS-1:0] payload;
  } cmd_t;

endpackage

@@ rtl/core/swfr_if.sv @@
`timescale 1ns / 1ps

interface swfr_in_if
  import swfr_pkg::*;
#(
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [OP_BITS-1:0]      operation;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [SEQ_BITS-1:0]     ack_number;
  logic                    ack_checksum_ok;
  logic [SEQ_BITS-1:0]     timeout_seq;

  modport source (
    output valid, operation, payload, ack_number, ack_checksum_ok, timeout_seq,
    input  ready
  );
  modport sink (
    input  valid, operation, payload, ack_number, ack_checksum_ok, timeout_seq,
    output ready
  );
endinterface

interface swfr_out_if
  import swfr_pkg::*;
#(
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [EV_BITS-1:0]      event_res;
  logic [SEQ_BITS-1:0]     event_seq;
  logic [PAYLOAD_BITS-1:0] event_payload;
  logic                    window_full;
  logic                    last;

  modport source (
    output valid, event_res, event_seq, event_payload, window_full, last,
    input  ready
  );
  modport sink (
    input  valid, event_res, event_seq, event_payload, window_full, last,
    output ready
  );
endinterface

@@ rtl/core/swfr_front.sv @@
`timescale 1ns / 1ps

module swfr_front
  import swfr_pkg::*;
#(
  parameter int WINDOW = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  swfr_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  localparam int OUT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = SEQ_BITS + 1;

  logic [OUT_W-1:0]    outstanding_r, outstanding_nxt;
  logic [SEQ_BITS-1:0] next_seq_r, next_seq_nxt;
  logic [SEQ_BITS-1:0] base_seq_r, base_seq_nxt;
  logic [1:0]          dup_count_r, dup_count_nxt;
  logic                waiting_r, waiting_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [SEQ_BITS-1:0] ack_dist;
  logic [SEQ_BITS-1:0] to_idx;
  logic                acc;
  cmd_t                cmd;

  // The offset never exceeds WINDOW, so one subtraction wraps the slot index.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] h,
                                                 input logic [SEQ_BITS-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(off);
    if (s >= SUM_W'(WINDOW)) begin
      s = s - SUM_W'(WINDOW);
    end
    return s[IDX_W-1:0];
  endfunction

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;
  assign q_push = acc;
  assign q_cmd = cmd;

  assign ack_dist = in_ch.ack_number - base_seq_r;
  assign to_idx = in_ch.timeout_seq - base_seq_r;

  always_comb begin
    outstanding_nxt = outstanding_r;
    next_seq_nxt = next_seq_r;
    base_seq_nxt = base_seq_r;
    dup_count_nxt = dup_count_r;
    waiting_nxt = waiting_r;
    head_nxt = head_r;
    cmd = '0;
    cmd.event_res = EV_NONE;
    cmd.count = CNT_BITS'(1);
    case (in_ch.operation)
      OP_SEND: begin
        if (waiting_r || int'(outstanding_r) >= WINDOW) begin
          cmd.event_res = EV_REFUSED;
          cmd.seq = next_seq_r;
        end else begin
          cmd.event_res = EV_TRANSMIT;
          cmd.seq = next_seq_r;
          cmd.slot = SLOT_BITS'(slot_add(head_r, SEQ_BITS'(outstanding_r)));
          cmd.wr_slot = 1'b1;
          cmd.payload = MAX_PAYLOAD_BITS'(in_ch.payload);
          if (outstanding_r == '0) begin
            base_seq_nxt = next_seq_r;
          end
          next_seq_nxt = next_seq_r + 1'b1;
          outstanding_nxt = outstanding_r + 1'b1;
          if (int'(outstanding_nxt) >= WINDOW) begin
            waiting_nxt = 1'b1;
          end
        end
      end
      OP_ACK: begin
        if (in_ch.ack_checksum_ok) begin
          if (in_ch.ack_number != base_seq_r) begin
            dup_count_nxt = 2'd1;
            if (int'(ack_dist) <= WINDOW && int'(ack_dist) <= int'(outstanding_r)) begin
              waiting_nxt = 1'b0;
              cmd.event_res = EV_STOP;
              cmd.seq = base_seq_r;
              cmd.count = CNT_BITS'(ack_dist);
              head_nxt = slot_add(head_r, ack_dist);
              outstanding_nxt = outstanding_r - OUT_W'(ack_dist);
              base_seq_nxt = in_ch.ack_number;
            end
          end else begin
            dup_count_nxt = (dup_count_r == DUP_LIMIT) ? 2'd1 : dup_count_r + 2'd1;
            if (dup_count_nxt == DUP_LIMIT && outstanding_r != '0) begin
              cmd.event_res = EV_RETRANSMIT;
              cmd.seq = base_seq_r;
              cmd.slot = SLOT_BITS'(head_r);
              cmd.rd_slot = 1'b1;
            end
          end
        end
      end
      OP_TIMEOUT: begin
        if (int'(to_idx) < int'(outstanding_r)) begin
          cmd.event_res = EV_RETRANSMIT;
          cmd.seq = in_ch.timeout_seq;
          cmd.slot = SLOT_BITS'(slot_add(head_r, to_idx));
          cmd.rd_slot = 1'b1;
        end
      end
      default: begin
      end
    endcase
    cmd.window_full = waiting_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
      next_seq_r <= '0;
      base_seq_r <= SEQ_BITS'(1);
      dup_count_r <= '0;
      waiting_r <= 1'b0;
      head_r <= '0;
    end else if (acc) begin
      outstanding_r <= outstanding_nxt;
      next_seq_r <= next_seq_nxt;
      base_seq_r <= base_seq_nxt;
      dup_count_r <= dup_count_nxt;
      waiting_r <= waiting_nxt;
      head_r <= head_nxt;
    end
  end

endmodule

@@ rtl/core/swfr_cmd_fifo.sv @@
`timescale 1ns / 1ps

module swfr_cmd_fifo
  import swfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/swfr_back.sv @@
`timescale 1ns / 1ps

module swfr_back
  import swfr_pkg::*;
#(
  parameter int WINDOW = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  swfr_out_if.source out_ch
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [PAYLOAD_BITS-1:0] mem [WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_data_r;

  back_state_t             state_r, state_nxt;
  logic [EV_BITS-1:0]      cur_res_r;
  logic [SEQ_BITS-1:0]     cur_seq_r;
  logic [CNT_BITS-1:0]     remain_r;
  logic                    cur_rd_r;
  logic                    cur_full_r;
  logic [PAYLOAD_BITS-1:0] cur_payload_r;

  logic                    out_valid_r;
  logic [EV_BITS-1:0]      out_res_r;
  logic [SEQ_BITS-1:0]     out_seq_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic                    out_full_r;
  logic                    out_last_r;

  logic                    out_free;
  logic                    emit;
  logic                    run_last;
  logic [IDX_W-1:0]        slot_idx;

  assign out_free = !out_valid_r || out_ch.ready;
  assign run_last = (remain_r == CNT_BITS'(1));
  assign slot_idx = q_cmd.slot[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (out_free && run_last) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    emit = 1'b0;
    case (state_r)
      B_IDLE: q_pop = !q_empty;
      B_RUN: emit = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr_slot) begin
      mem[slot_idx] <= q_cmd.payload[PAYLOAD_BITS-1:0];
    end
    if (q_pop) begin
      rd_data_r <= mem[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_res_r <= q_cmd.event_res;
      cur_rd_r <= q_cmd.rd_slot;
      cur_full_r <= q_cmd.window_full;
      cur_payload_r <= q_cmd.payload[PAYLOAD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      remain_r <= '0;
      cur_seq_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        remain_r <= q_cmd.count;
        cur_seq_r <= q_cmd.seq;
      end else if (emit) begin
        remain_r <= remain_r - 1'b1;
        cur_seq_r <= cur_seq_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= cur_res_r;
      out_seq_r <= cur_seq_r;
      out_payload_r <= cur_rd_r ? rd_data_r : cur_payload_r;
      out_full_r <= cur_full_r;
      out_last_r <= run_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.event_res = out_res_r;
  assign out_ch.event_seq = out_seq_r;
  assign out_ch.event_payload = out_payload_r;
  assign out_ch.window_full = out_full_r;
  assign out_ch.last = out_last_r;

endmodule

@@ rtl/core/sliding_window_sender_fast_retransmit.sv @@
// The first result of an item passes through the request queue and the result sequencer
// before it reaches the output register. Throughput: the sequencer emits one result per
// cycle while the output is not stalled and takes no new item until its last result is out.
// A two-entry request queue lets the input side accept while the sequencer is busy.
// Reset (rst_n low, synchronous) empties the window, sets the base sequence to 1 and clears
// the queue and the output valid flag; the payload store is not cleared.
`timescale 1ns / 1ps

module sliding_window_sender_fast_retransmit
  import swfr_pkg::*;
#(
  parameter int WINDOW = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  swfr_in_if.sink    in_ch,
  swfr_out_if.source out_ch
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  swfr_front #(
    .WINDOW(WINDOW),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd(push_cmd)
  );

  swfr_cmd_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data(push_cmd),
    .full(q_full),
    .pop(q_pop),
    .pop_data(pop_cmd),
    .empty(q_empty)
  );

  swfr_back #(
    .WINDOW(WINDOW),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .q_cmd(pop_cmd),
    .q_pop(q_pop),
    .out_ch(out_ch)
  );

endmodule

@@ rtl/core/swfr_checker.sv @@
`timescale 1ns / 1ps

module swfr_checker
  import swfr_pkg::*;
#(
  parameter int PAYLOAD_BITS = 64
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [EV_BITS-1:0]      out_event_res,
  input logic [SEQ_BITS-1:0]     out_event_seq,
  input logic [PAYLOAD_BITS-1:0] out_event_payload,
  input logic                    out_window_full,
  input logic                    out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) &&
      $stable(out_event_seq) && $stable(out_event_payload) &&
      $stable(out_window_full) && $stable(out_last))
    else $error("Result changed while stalled.");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_REFUSED |-> out_window_full)
    else $error("Refused request with window not full.");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_STOP |-> out_last)
    else $error("Single-result request not marked last.");

  a_stop_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_event_res == EV_STOP && !out_last |=>
      out_valid && out_event_res == EV_STOP &&
      out_event_seq == $past(out_event_seq) + 3'd1)
    else $error("Timer stop run broken.");

endmodule

bind sliding_window_sender_fast_retransmit swfr_checker #(
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_swfr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_event_res(out_ch.event_res),
  .out_event_seq(out_ch.event_seq),
  .out_event_payload(out_ch.event_payload),
  .out_window_full(out_ch.window_full),
  .out_last(out_ch.last)
);
